>>> rtl/otsu_pkg.sv
`timescale 1ns / 1ps

package otsu_pkg;

	// default slot count
	localparam int unsigned SLOTS_DEF = 8;

	// fixed field widths
	localparam int unsigned OP_W    = 3;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned DELAY_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_SCHEDULE = 3'd0,
		OP_POSTPONE = 3'd1,
		OP_CANCEL   = 3'd2,
		OP_QUERY    = 3'd3,
		OP_TICK     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EMIT
	} fsm_t;

	// outcome of one slot visit during a tick sweep
	typedef struct packed {
		logic [DELAY_W-1:0] count;
		logic               hit;
	} step_res_t;

endpackage

>>> rtl/otsu_step.sv
`timescale 1ns / 1ps

// shared slot unit: bump the elapsed count, compare against the limit
module otsu_step (
	input  logic [otsu_pkg::DELAY_W-1:0] count,
	input  logic [otsu_pkg::DELAY_W-1:0] limit,
	output otsu_pkg::step_res_t          res
);

	import otsu_pkg::*;

	logic [DELAY_W-1:0] count_inc;

	assign count_inc = count + DELAY_W'(1);   // wraps, as a byte counter does

	always_comb begin
		res.count = count_inc;
		res.hit   = (count_inc >= limit);
	end

endmodule

>>> rtl/one_shot_timer_slots_unit.sv
`timescale 1ns / 1ps

// Table of SLOTS one-shot timers driven by a command word on start/busy.
// A word is taken at a rising edge with start high and busy low. Schedule,
// postpone, cancel, query, an unknown code, and a tick that arrives while
// ticking is off all finish in the accept cycle: busy stays low, so such
// words may follow every cycle, and the single result word shows in the cycle
// after the accept edge. A tick while ticking is on raises busy and walks
// the slots one per cycle through a single increment-and-compare unit,
// then emits one result word per fired slot in ascending
// slot order, or one word with fired low if none fired, one word a cycle.
// The last word (last high) is on the ports in the first cycle after busy
// falls. Each result word holds for exactly one cycle under strobe and
// cannot be stalled: the receiver must take it then. ticking gives the
// state of the tick source after the command that caused the word.
module one_shot_timer_slots_unit #(
	parameter int unsigned SLOTS = otsu_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [otsu_pkg::OP_W-1:0]    operation,
	input  logic [otsu_pkg::SLOT_W-1:0]  slot,
	input  logic [otsu_pkg::DELAY_W-1:0] delay,
	output logic                         strobe,
	output logic                         fired,
	output logic [otsu_pkg::SLOT_W-1:0]  fired_slot,
	output logic                         slot_idle,
	output logic                         ticking,
	output logic                         last
);

	import otsu_pkg::*;

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(SLOTS - 1);

	// ---- state ----
	fsm_t               state_q, state_d;
	logic [DELAY_W-1:0] count_q [SLOTS];
	logic [DELAY_W-1:0] limit_q [SLOTS];
	logic [SLOTS-1:0]   armed_q, armed_d;
	logic               tick_en_q, tick_en_d;
	logic [SLOTS-1:0]   hit_q, hit_d;      // slots fired by the current tick
	logic [IDX_W-1:0]   sweep_q;

	// ---- result register ----
	logic               strobe_q;
	logic               fired_q;
	logic [SLOT_W-1:0]  fired_slot_q;
	logic               slot_idle_q;
	logic               ticking_q;
	logic               last_q;

	// ---- datapath controls ----
	logic               accept;
	logic               slot_ok;
	logic [IDX_W-1:0]   idx;
	logic               cnt_we;
	logic [DELAY_W-1:0] cnt_wdata;
	logic               lim_we;
	logic               res_vld;
	logic               res_fired;
	logic [SLOT_W-1:0]  res_slot;
	logic               res_idle;
	logic               res_last;
	logic [SLOT_W-1:0]  pick;
	step_res_t          step;

	assign slot_ok = ({1'b0, slot} < (SLOT_W + 1)'(SLOTS));

	// one table port: the sweep counter while walking, else the command slot
	assign idx = (state_q == ST_SWEEP) ? sweep_q : slot[IDX_W-1:0];

	otsu_step u_step (
		.count (count_q[idx]),
		.limit (limit_q[idx]),
		.res   (step)
	);

	// lowest pending fired slot
	always_comb begin
		pick = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				pick = SLOT_W'(i);
			end
		end
	end

	// ---- FSM: control outputs ----
	always_comb begin
		busy   = (state_q != ST_IDLE);
		accept = start && (state_q == ST_IDLE);
	end

	// ---- datapath ----
	always_comb begin
		cnt_we    = 1'b0;
		cnt_wdata = step.count;
		lim_we    = 1'b0;
		armed_d   = armed_q;
		tick_en_d = tick_en_q;
		hit_d     = hit_q;
		res_vld   = 1'b0;
		res_fired = 1'b0;
		res_slot  = '0;
		res_idle  = 1'b0;
		res_last  = 1'b0;

		if (accept) begin
			if (operation == OP_TICK) begin
				hit_d = '0;
				if (!tick_en_q) begin
					// tick source off: ignored, one empty word
					res_vld  = 1'b1;
					res_last = 1'b1;
				end
			end else begin
				res_vld  = 1'b1;
				res_last = 1'b1;
				if (slot_ok) begin
					unique case (operation)
						OP_SCHEDULE: begin
							cnt_we       = 1'b1;
							cnt_wdata    = '0;
							lim_we       = 1'b1;
							armed_d[idx] = 1'b1;
							tick_en_d    = 1'b1;
						end
						OP_POSTPONE: begin
							cnt_we    = 1'b1;
							cnt_wdata = '0;
						end
						OP_CANCEL: begin
							armed_d[idx] = 1'b0;
							if (armed_d == '0) begin
								tick_en_d = 1'b0;
							end
						end
						OP_QUERY: begin
							res_idle = !armed_q[idx];
						end
						default: begin
							// unknown code: no effect
						end
					endcase
				end
			end
		end

		if (state_q == ST_SWEEP) begin
			if (armed_q[idx]) begin
				cnt_we = 1'b1;
				if (step.hit) begin
					armed_d[idx] = 1'b0;
					hit_d[idx]   = 1'b1;
				end
			end
			// source stops once a firing leaves the table empty
			if (sweep_q == SWEEP_LAST && hit_d != '0 && armed_d == '0) begin
				tick_en_d = 1'b0;
			end
		end

		if (state_q == ST_EMIT) begin
			res_vld = 1'b1;
			if (hit_q != '0) begin
				res_fired = 1'b1;
				res_slot  = pick;
				hit_d     = hit_q & (hit_q - SLOTS'(1));   // drop lowest set bit
				res_last  = (hit_d == '0);
			end else begin
				res_last  = 1'b1;
			end
		end
	end

	// ---- FSM: next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_TICK && tick_en_q) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (hit_d == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			armed_q   <= '0;
			tick_en_q <= 1'b0;
			hit_q     <= '0;
			sweep_q   <= '0;
			strobe_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			armed_q   <= armed_d;
			tick_en_q <= tick_en_d;
			hit_q     <= hit_d;
			strobe_q  <= res_vld;
			if (state_q == ST_SWEEP) begin
				sweep_q <= (sweep_q == SWEEP_LAST) ? '0 : sweep_q + IDX_W'(1);
			end
		end
	end

	// count and limit only matter once the slot is armed, and schedule
	// writes both; reset still clears them to match the table's start state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				count_q[i] <= '0;
				limit_q[i] <= '0;
			end
		end else begin
			if (cnt_we) begin
				count_q[idx] <= cnt_wdata;
			end
			if (lim_we) begin
				limit_q[idx] <= delay;
			end
		end
	end

	// ---- result payload ----
	always_ff @(posedge clk) begin
		if (res_vld) begin
			fired_q      <= res_fired;
			fired_slot_q <= res_slot;
			slot_idle_q  <= res_idle;
			ticking_q    <= tick_en_d;
			last_q       <= res_last;
		end
	end

	assign strobe     = strobe_q;
	assign fired      = fired_q;
	assign fired_slot = fired_slot_q;
	assign slot_idle  = slot_idle_q;
	assign ticking    = ticking_q;
	assign last       = last_q;

	// ---- assertions ----
	// an armed slot always has the tick source running
	a_armed_ticking: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q != '0) |-> tick_en_q)
		else $error("slot armed with tick source off");

	// sweep ends in the emit phase
	a_sweep_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && sweep_q == SWEEP_LAST) |=> (state_q == ST_EMIT))
		else $error("sweep did not hand over to emit");

	// a burst of fired words is unbroken until last
	a_burst_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |=> strobe_q)
		else $error("gap inside a result burst");

	// commands other than a tick answer next cycle with one final word
	a_cmd_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation != OP_TICK) |=> (strobe_q && last_q && !fired_q))
		else $error("command word not answered");

	// a fired word never carries a query answer
	a_fired_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && fired_q) |-> !slot_idle_q)
		else $error("fired word with slot_idle set");

endmodule

>>> tb/tb_one_shot_timer_slots_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the one-shot timer table.
// A directed list goes first, then a random mix that is mostly schedules and
// ticks, so that slots really run down and fire. Command words come from a
// queue and are driven at the falling edge. The same word is predicted at
// the rising edge that accepts it, and result words are checked there too.
module tb_one_shot_timer_slots_unit;

	import otsu_pkg::*;

	localparam int unsigned SLOTS       = SLOTS_DEF;
	localparam int unsigned IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned SLOT_MAX    = (1 << SLOT_W) - 1;
	localparam int unsigned RAND_CMDS   = 106;
	localparam int unsigned IDLE_PCT    = 24;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_REPORTS = 10;

	// codes 5..7 are not decoded by the block
	localparam logic [OP_W-1:0] OP_RSVD_LO = OP_TICK + 1'b1;
	localparam logic [OP_W-1:0] OP_RSVD_HI = '1;

	// one command word; hold = wait for every outstanding result before sending
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  slot;
		logic [DELAY_W-1:0] delay;
		logic               hold;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic              fired;
		logic [SLOT_W-1:0] fired_slot;
		logic              slot_idle;
		logic              ticking;
		logic              last;
	} res_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [OP_W-1:0]    operation = '0;
	logic [SLOT_W-1:0]  slot = '0;
	logic [DELAY_W-1:0] delay = '0;
	logic               busy;
	logic               strobe;
	logic               fired;
	logic [SLOT_W-1:0]  fired_slot;
	logic               slot_idle;
	logic               ticking;
	logic               last;

	one_shot_timer_slots_unit #(
		.SLOTS(SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.slot      (slot),
		.delay     (delay),
		.strobe    (strobe),
		.fired     (fired),
		.fired_slot(fired_slot),
		.slot_idle (slot_idle),
		.ticking   (ticking),
		.last      (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// pending command words, and result words still to come
	cmd_t      cmd_q[$];
	res_word_t due_q[$];

	// shadow timer table
	logic [DELAY_W-1:0] cnt_m [SLOTS];
	logic [DELAY_W-1:0] lim_m [SLOTS];
	logic               arm_m [SLOTS];
	logic               tick_on_m = 1'b0;

	int unsigned cycles = 0;
	int unsigned sent = 0;
	int unsigned checked = 0;
	int unsigned firings = 0;
	int unsigned most_fired = 0;
	int unsigned bad = 0;
	logic        on_air = 1'b0;	// a word is on the command ports
	logic        took = 1'b0;	// that word went in at the last rising edge
	cmd_t        cur = '0;

	function automatic void add_cmd(int unsigned op, int unsigned sl,
			int unsigned dl, int unsigned hold);
		cmd_t c;
		c.op = OP_W'(op);
		c.slot = SLOT_W'(sl);
		c.delay = DELAY_W'(dl);
		c.hold = (hold != 0);
		cmd_q.push_back(c);
	endfunction

	// Apply one accepted word to the shadow table and queue the words it causes.
	function automatic void timer_table_step(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sl,
			logic [DELAY_W-1:0] dl);
		logic [SLOT_W-1:0] hit_list [SLOTS];
		int unsigned       n;
		logic              any_armed;
		logic              idle;
		logic [IDX_W-1:0]  si;
		res_word_t         w;
		n = 0;
		idle = 1'b0;
		si = sl[IDX_W-1:0];
		if (op == OP_TICK) begin
			if (tick_on_m) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (arm_m[i]) begin
						cnt_m[i] = cnt_m[i] + 1'b1;
						if (cnt_m[i] >= lim_m[i]) begin
							arm_m[i] = 1'b0;
							hit_list[n] = SLOT_W'(i);
							n++;
						end
					end
				end
			end
		end else if (sl < SLOTS) begin
			case (op)
				OP_SCHEDULE: begin
					cnt_m[si] = '0;
					lim_m[si] = dl;
					arm_m[si] = 1'b1;
					tick_on_m = 1'b1;
				end
				OP_POSTPONE: begin
					cnt_m[si] = '0;
				end
				OP_CANCEL: begin
					arm_m[si] = 1'b0;
				end
				OP_QUERY: begin
					idle = !arm_m[si];
				end
				default: begin
				end
			endcase
		end
		// a firing or a cancel that leaves the table empty stops the tick source
		if ((op == OP_TICK && n > 0) || (op == OP_CANCEL && sl < SLOTS)) begin
			any_armed = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				any_armed |= arm_m[i];
			if (!any_armed)
				tick_on_m = 1'b0;
		end
		if (n > most_fired)
			most_fired = n;
		w = '0;
		w.ticking = tick_on_m;
		if (n == 0) begin
			w.slot_idle = idle;
			w.last = 1'b1;
			due_q.push_back(w);
		end else begin
			for (int k = 0; k < n; k++) begin
				w.fired = 1'b1;
				w.fired_slot = hit_list[k];
				w.last = (k == n - 1);
				due_q.push_back(w);
			end
		end
	endfunction

	// Monitor: check result words first (they belong to earlier words),
	// then predict the word accepted at this edge.
	always @(posedge clk) begin
		res_word_t want;
		res_word_t got;
		if (arst_n) begin
			if (strobe) begin
				got = '{fired, fired_slot, slot_idle, ticking, last};
				if (fired)
					firings++;
				if (due_q.size() == 0) begin
					bad++;
					if (bad <= MAX_REPORTS)
						$display("unexpected result word: fired=%0b slot=%0d %s%0b %s%0b %s%0b",
							got.fired, got.fired_slot, "idle=", got.slot_idle,
							"tick=", got.ticking, "last=", got.last);
				end else begin
					want = due_q.pop_front();
					checked++;
					if (got !== want) begin
						bad++;
						if (bad <= MAX_REPORTS) begin
							$display("%0t: want fired=%0b slot=%0d idle=%0b tick=%0b last=%0b",
								$realtime, want.fired, want.fired_slot, want.slot_idle,
								want.ticking, want.last);
							$display("    got  fired=%0b slot=%0d idle=%0b tick=%0b last=%0b",
								got.fired, got.fired_slot, got.slot_idle,
								got.ticking, got.last);
						end
					end
				end
			end
			if (start && !busy)
				timer_table_step(operation, slot, delay);
		end
		took <= arst_n && start && !busy;
	end

	// Driver: a word stays on the ports until taken; gaps only between words.
	// Words 70..129 skip the random idle gaps.
	always @(negedge clk) begin
		logic quiet;
		quiet = (sent >= 70 && sent < 130);
		if (arst_n) begin
			if (on_air && took) begin
				on_air = 1'b0;
				sent++;
			end
			if (!on_air && cmd_q.size() > 0) begin
				if (cmd_q[0].hold && (due_q.size() != 0 || busy)) begin
					// hold off until the table has answered everything
				end else if (quiet || $urandom_range(0, 99) >= IDLE_PCT) begin
					cur = cmd_q.pop_front();
					on_air = 1'b1;
				end
			end
		end
		start <= on_air;
		operation <= cur.op;
		slot <= cur.slot;
		delay <= cur.delay;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_one_shot_timer_slots_unit NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned       r;
		int unsigned       dr;
		int unsigned       sl;
		int unsigned       sl_any;
		int unsigned       bad_sl;
		int unsigned       dl;
		logic              hold;

		for (int i = 0; i < SLOTS; i++) begin
			cnt_m[i] = '0;
			lim_m[i] = '0;
			arm_m[i] = 1'b0;
		end

		// directed: empty table, out-of-range slots, unknown codes
		add_cmd(OP_QUERY, 0, 0, 0);
		add_cmd(OP_TICK, 0, 0, 0);			// ticking off: ignored
		add_cmd(OP_SCHEDULE, SLOT_MAX, '1, 0);		// slot out of range
		add_cmd(OP_QUERY, SLOT_MAX, 0, 0);		// answers not idle
		add_cmd(OP_POSTPONE, SLOTS + 1, 0, 0);
		add_cmd(OP_CANCEL, SLOTS, 0, 0);
		add_cmd(OP_CANCEL, 3, 0, 0);			// cancel of an idle slot
		add_cmd(OP_RSVD_LO, SLOT_MAX, '1, 0);
		add_cmd(OP_RSVD_LO + 1'b1, 0, 0, 0);
		add_cmd(OP_RSVD_HI, SLOT_MAX, '1, 0);
		// zero delay fires on the first tick
		add_cmd(OP_SCHEDULE, 0, 0, 0);
		add_cmd(OP_TICK, 0, 0, 0);
		// every slot fires on one tick
		for (int i = 0; i < SLOTS; i++)
			add_cmd(OP_SCHEDULE, i, 1, 0);
		add_cmd(OP_TICK, SLOT_MAX, '1, 0);
		// rearm, postpone and cancel of an armed slot
		add_cmd(OP_SCHEDULE, SLOTS - 1, '1, 0);
		add_cmd(OP_QUERY, SLOTS - 1, 0, 0);
		add_cmd(OP_SCHEDULE, SLOTS - 1, 2, 0);
		add_cmd(OP_POSTPONE, SLOTS - 1, 0, 0);
		add_cmd(OP_TICK, 0, 0, 0);
		add_cmd(OP_CANCEL, SLOTS - 1, 0, 0);
		add_cmd(OP_TICK, 0, 0, 1);

		// random: mostly schedules and ticks with short delays
		for (int n = 0; n < RAND_CMDS; n++) begin
			r = $urandom_range(0, 99);
			dr = $urandom_range(0, 99);
			sl = $urandom_range(0, SLOTS - 1);
			bad_sl = $urandom_range(SLOTS, SLOT_MAX);
			sl_any = ($urandom_range(0, 9) == 0) ? bad_sl : sl;
			dl = (dr < 80) ? $urandom_range(0, 6) :
				(dr < 95) ? $urandom_range(7, 30) : $urandom_range(0, 255);
			hold = (n == 40 || n == 90);
			if (n == 100) begin
				// long delay: the count runs well up before the slot fires
				add_cmd(OP_SCHEDULE, 5, 24, 0);
				for (int t = 0; t < 24; t++)
					add_cmd(OP_TICK, $urandom_range(0, SLOT_MAX), $urandom_range(0, 255), 0);
				add_cmd(OP_QUERY, 5, 0, 0);
			end
			if (r < 24)
				add_cmd(OP_SCHEDULE, sl, dl, hold);
			else if (r < 31)
				add_cmd(OP_POSTPONE, sl_any, $urandom_range(0, 255), hold);
			else if (r < 38)
				add_cmd(OP_CANCEL, sl_any, $urandom_range(0, 255), hold);
			else if (r < 45)
				add_cmd(OP_QUERY, $urandom_range(0, SLOT_MAX), $urandom_range(0, 255), hold);
			else if (r < 48)
				add_cmd(OP_SCHEDULE, bad_sl, dl, hold);
			else if (r < 50)
				add_cmd($urandom_range(OP_RSVD_LO, OP_RSVD_HI), $urandom_range(0, SLOT_MAX),
					$urandom_range(0, 255), hold);
			else
				add_cmd(OP_TICK, $urandom_range(0, SLOT_MAX), $urandom_range(0, 255), hold);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || on_air || due_q.size() != 0)
			@(posedge clk);
		// a tick sweep visits every slot, then sends up to SLOTS result words
		repeat (2 * SLOTS + 4) @(posedge clk);

		bad += due_q.size();
		$display("run: %0d command words, %0d result words checked, %0d slot firings",
			sent, checked, firings);
		$display("run: up to %0d slots fired on one tick, %0d errors", most_fired, bad);
		if (bad == 0)
			$display("tb_one_shot_timer_slots_unit OK");
		else
			$display("tb_one_shot_timer_slots_unit NOT OK");
		$finish;
	end

endmodule
